>>> hdl/slist_pkg.sv
// Shared constants, codes and handshake structs for the sequential list engine.
package slist_pkg;

  // List storage geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of one beat on either side
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + COUNT_W + 7) / 8) * 8;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_GET        = 3'd2,
    OP_REMOVE_ODD = 3'd3,
    OP_MAX        = 3'd4,
    OP_SIZE       = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the command beat and set up the walk
    logic scan;    // walk the stored entries
    logic finish;  // write back and post the result beat
  } slist_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // every entry read and processed
    logic out_free;   // result register can take a new beat
  } slist_sts_t;

endpackage

>>> hdl/sequential_list_engine.sv
// Top level of the sequential list engine: stream ports, controller and datapath.
//
// Bounded list of up to 32 signed Q16.16 entries driven by one command beat at a time;
// every command beat yields exactly one result beat. Remove, remove-odd and max walk all
// stored entries (setup, reads, registered read data, then write-back), a get that hits
// reads only its own entry, and a get out of range, append, size, clear, unused codes
// and any walk over an empty list read none. The entry memory is read one entry per
// cycle while removals close gaps in the same pass. The next command is taken once the
// previous result sits in the output register, so a waiting result does not stall the
// input side until the following one is done.
module sequential_list_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [slist_pkg::IN_DATA_W-1:0]       in_tdata,   // value[31:0], position[37:32]
  input  logic [slist_pkg::OP_W-1:0]            in_tuser,   // opcode[2:0]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [slist_pkg::OUT_DATA_W-1:0]      out_tdata,  // result_value[31:0], count[37:32]
  output logic [0:0]                            out_tuser   // status[0]
);

  localparam int VAL_W   = slist_pkg::VAL_W;
  localparam int POS_W   = slist_pkg::POS_W;
  localparam int COUNT_W = slist_pkg::COUNT_W;

  slist_pkg::slist_cmd_t cmd;
  slist_pkg::slist_sts_t sts;

  logic                  res_status;
  logic [VAL_W-1:0]      res_value;
  logic [COUNT_W-1:0]    res_count;

  slist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slist_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_tuser),
    .in_value         (in_tdata[VAL_W-1:0]),
    .in_position      (in_tdata[VAL_W+POS_W-1:VAL_W]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (res_status),
    .out_result_value (res_value),
    .out_count        (res_count)
  );

  // Pack the result beat
  assign out_tdata = slist_pkg::OUT_DATA_W'({res_count, res_value});
  assign out_tuser = res_status;

endmodule

>>> hdl/slist_ctrl.sv
// Controller state machine: accept a command, run the walk, post the result.
module slist_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  slist_pkg::slist_sts_t  sts,
  output slist_pkg::slist_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/slist_dp.sv
// Datapath: entry memory, walk counters, compaction, max search and result register.
module slist_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slist_pkg::slist_cmd_t             cmd,
  output slist_pkg::slist_sts_t             sts,
  input  logic [slist_pkg::OP_W-1:0]        in_opcode,
  input  logic [slist_pkg::VAL_W-1:0]       in_value,
  input  logic [slist_pkg::POS_W-1:0]       in_position,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_status,
  output logic [slist_pkg::VAL_W-1:0]       out_result_value,
  output logic [slist_pkg::COUNT_W-1:0]     out_count
);

  localparam int IDX_W = slist_pkg::IDX_W;
  localparam int CNT_W = slist_pkg::CNT_W;
  localparam int CMP_W = slist_pkg::CMP_W;
  localparam int VAL_W = slist_pkg::VAL_W;

  // Entry storage; a read returns the old entry on a same-address write
  logic [VAL_W-1:0] mem [slist_pkg::CAPACITY];

  slist_pkg::op_t   op_r;
  logic [VAL_W-1:0] val_r;
  logic             get_ok_r;
  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] rd_idx_r;
  logic [CMP_W-1:0] end_r;
  logic [CNT_W-1:0] wr_idx_r;
  logic             found_r;
  logic             have_r;
  logic [VAL_W-1:0] best_r;
  logic [VAL_W-1:0] q_r;
  logic             q_vld_r;

  logic             out_valid_r;
  logic             out_status_r;
  logic [VAL_W-1:0] out_result_r;
  logic [CNT_W-1:0] out_count_r;

  slist_pkg::op_t   in_op;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             in_get_ok;
  logic             issue;
  logic [VAL_W-1:0] q_neg;
  logic             q_odd;
  logic             q_hit;
  logic             q_keep;
  logic             compact_op;
  logic             search_op;
  logic             room;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic             fin_status;
  logic [VAL_W-1:0] fin_result;
  logic [CNT_W-1:0] fin_count;

  assign in_op     = slist_pkg::op_t'(in_opcode);
  assign pos_ext   = CMP_W'(in_position);
  assign cnt_ext   = CMP_W'(count_r);
  assign in_get_ok = (in_position != '0) && (pos_ext <= cnt_ext);
  assign room      = (count_r < CNT_W'(slist_pkg::CAPACITY));

  // Walk one entry per cycle while reads remain
  assign issue = cmd.scan && (rd_idx_r < end_r);

  // Odd test on the magnitude of the truncated integer part
  assign q_neg  = ~q_r + VAL_W'(1);
  assign q_odd  = q_r[VAL_W-1] ? q_neg[16] : q_r[16];
  assign q_hit  = !found_r && (q_r == val_r);
  assign q_keep = (op_r == slist_pkg::OP_REMOVE_ODD) ? !q_odd : !q_hit;

  assign compact_op = (op_r == slist_pkg::OP_REMOVE) || (op_r == slist_pkg::OP_REMOVE_ODD);
  assign search_op  = (op_r == slist_pkg::OP_MAX) || (op_r == slist_pkg::OP_GET);

  // Single write port: compaction during the walk, append at finish
  always_comb begin
    we    = 1'b0;
    waddr = wr_idx_r[IDX_W-1:0];
    wdata = q_r;
    if (q_vld_r && compact_op && q_keep) begin
      we = 1'b1;
    end else if (cmd.finish && (op_r == slist_pkg::OP_APPEND) && room) begin
      we    = 1'b1;
      waddr = count_r[IDX_W-1:0];
      wdata = val_r;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      q_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // Outcome of the command
  always_comb begin
    fin_status = 1'b1;
    fin_result = '0;
    fin_count  = count_r;
    case (op_r)
      slist_pkg::OP_APPEND: begin
        if (room) begin
          fin_status = 1'b0;
          fin_count  = count_r + CNT_W'(1);
        end
      end
      slist_pkg::OP_REMOVE: begin
        fin_status = !found_r;
        fin_count  = wr_idx_r;
      end
      slist_pkg::OP_GET: begin
        if (get_ok_r) begin
          fin_status = 1'b0;
          fin_result = best_r;
        end
      end
      slist_pkg::OP_REMOVE_ODD: begin
        fin_status = (count_r == '0);
        fin_count  = wr_idx_r;
      end
      slist_pkg::OP_MAX: begin
        if (count_r != '0) begin
          fin_status = 1'b0;
          fin_result = best_r;
        end
      end
      slist_pkg::OP_SIZE: begin
        fin_status = 1'b0;
      end
      slist_pkg::OP_CLEAR: begin
        fin_status = 1'b0;
        fin_count  = '0;
      end
      default: begin
        fin_status = 1'b1;
      end
    endcase
  end

  // Command capture, walk counters and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
      end_r    <= '0;
      wr_idx_r <= '0;
      q_vld_r  <= 1'b0;
    end else begin
      q_vld_r <= issue;
      if (cmd.load) begin
        wr_idx_r <= '0;
        rd_idx_r <= '0;
        end_r    <= '0;
        case (in_op) inside
          slist_pkg::OP_GET: begin
            if (in_get_ok) begin
              rd_idx_r <= pos_ext - CMP_W'(1);
              end_r    <= pos_ext;
            end
          end
          slist_pkg::OP_REMOVE, slist_pkg::OP_REMOVE_ODD, slist_pkg::OP_MAX: begin
            end_r <= cnt_ext;
          end
          default: begin
            end_r <= '0;
          end
        endcase
      end else begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + CMP_W'(1);
        end
        if (q_vld_r && compact_op && q_keep) begin
          wr_idx_r <= wr_idx_r + CNT_W'(1);
        end
      end
      if (cmd.finish) begin
        count_r <= fin_count;
      end
    end
  end

  // Payload side: operand, hit flag and best value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      val_r    <= in_value;
      get_ok_r <= in_get_ok;
      found_r  <= 1'b0;
      have_r   <= 1'b0;
      best_r   <= '0;
    end else if (q_vld_r) begin
      if ((op_r == slist_pkg::OP_REMOVE) && q_hit) begin
        found_r <= 1'b1;
      end
      if (search_op && (!have_r || ($signed(q_r) > $signed(best_r)))) begin
        best_r <= q_r;
        have_r <= 1'b1;
      end
    end
  end

  // Result register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= fin_status;
      out_result_r <= fin_result;
      out_count_r  <= fin_count;
    end
  end

  assign sts.scan_done = !(rd_idx_r < end_r) && !q_vld_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;
  assign out_count        = slist_pkg::COUNT_W'(out_count_r);

  // Compaction write pointer never passes the read pointer
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(wr_idx_r) <= rd_idx_r)
    else $error("write pointer ahead of read pointer");

  // Fill count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(slist_pkg::CAPACITY))
    else $error("fill count above capacity");

  // A result is only posted into a free output register
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result posted over a pending beat");

  // Read data only arrives after a walk cycle
  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> $past(cmd.scan))
    else $error("read data outside a walk");

endmodule

>>> sim/sequential_list_engine_tb.sv
// Self-checking bench for the sequential list engine: list predictor, random traffic, stalls.
module sequential_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [slist_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 490;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 1_000_000;

  // Q16.16 corners used by the directed part
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;
  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG_1P5  = 32'hFFFE_8000;
  localparam logic [31:0] Q_NEG_2P5  = 32'hFFFD_8000;
  localparam logic [31:0] Q_POS_1P5  = 32'h0001_8000;
  localparam logic [31:0] Q_ABSENT   = 32'h1234_5678;

  typedef struct {
    logic        status;
    logic [31:0] value;
    logic [5:0]  count;
  } list_reply_t;

  // Shadow list plus the replies it predicts, oldest first
  class list_scoreboard;
    logic [31:0] entries[$];
    list_reply_t replies[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Truncated integer part odd, judged by magnitude
    function bit odd_int_part(logic [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? (~v + 32'd1) : v;
      return mag[16];
    endfunction

    // Apply one accepted command beat and queue the reply it must produce
    function void note_command(logic [slist_pkg::OP_W-1:0] op, logic [31:0] val,
                               logic [5:0] pos);
      list_reply_t r;
      logic [31:0] kept[$];
      logic [31:0] best;
      r.status = 1'b1;
      r.value  = '0;
      case (op)
        slist_pkg::OP_APPEND: begin
          if (entries.size() < slist_pkg::CAPACITY) begin
            entries.push_back(val);
            r.status = 1'b0;
          end
        end
        slist_pkg::OP_REMOVE: begin
          foreach (entries[i]) begin
            if (entries[i] == val) begin
              entries.delete(i);
              r.status = 1'b0;
              break;
            end
          end
        end
        slist_pkg::OP_GET: begin
          if (pos != 0 && pos <= entries.size()) begin
            r.value  = entries[pos - 1];
            r.status = 1'b0;
          end
        end
        slist_pkg::OP_REMOVE_ODD: begin
          if (entries.size() != 0) begin
            foreach (entries[i])
              if (!odd_int_part(entries[i])) kept.push_back(entries[i]);
            entries  = kept;
            r.status = 1'b0;
          end
        end
        slist_pkg::OP_MAX: begin
          if (entries.size() != 0) begin
            best = entries[0];
            foreach (entries[i])
              if ($signed(entries[i]) > $signed(best)) best = entries[i];
            r.value  = best;
            r.status = 1'b0;
          end
        end
        slist_pkg::OP_SIZE: r.status = 1'b0;
        slist_pkg::OP_CLEAR: begin
          entries.delete();
          r.status = 1'b0;
        end
        default: ;
      endcase
      r.count = 6'(entries.size());
      replies.push_back(r);
    endfunction

    // Compare one result beat with the oldest predicted reply
    function void check_result(logic st, logic [31:0] v, logic [5:0] c);
      list_reply_t want;
      if (replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result beat: status=%0b value=%h count=%0d",
                   $realtime, st, v, c);
        return;
      end
      want = replies.pop_front();
      if (want.status !== st || want.value !== v || want.count !== c) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] mismatch: exp status=%0b value=%h count=%0d, ",
                    "got status=%0b value=%h count=%0d"},
                   $realtime, want.status, want.value, want.count, st, v, c);
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [slist_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [slist_pkg::OP_W-1:0]       in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [slist_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                       out_tuser;

  list_scoreboard sb;
  bit             hold_req;
  int             send_calm;
  int             recv_calm;
  int             cycles;

  sequential_list_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("sequential_list_engine_tb: FAIL");
      $finish;
    end
  end

  // Mostly short idles, a few long ones, and calm stretches with none
  function automatic int pick_idle(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Operand mix: stored copies, small Q16.16 with both parities, corners, raw bits
  function automatic logic [31:0] pick_value();
    int r;
    int ip;
    r = $urandom_range(0, 99);
    if (r < 25 && sb.entries.size() != 0)
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    if (r < 55) begin
      ip = $urandom_range(0, 16) - 8;
      return {16'(ip), 16'($urandom_range(0, 65535))};
    end
    if (r < 70) begin
      case ($urandom_range(0, 5))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        4: return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_removal();
    if (sb.entries.size() != 0 && $urandom_range(0, 99) < 70)
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [5:0] pick_position();
    if (sb.entries.size() != 0 && $urandom_range(0, 99) < 80)
      return 6'($urandom_range(1, sb.entries.size()));
    return 6'($urandom_range(0, 63));
  endfunction

  // Grow phases favor append, shrink phases favor removal
  function automatic logic [slist_pkg::OP_W-1:0] pick_op(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 55) return slist_pkg::OP_APPEND;
      if (r < 65) return slist_pkg::OP_REMOVE;
      if (r < 78) return slist_pkg::OP_GET;
      if (r < 82) return slist_pkg::OP_REMOVE_ODD;
      if (r < 90) return slist_pkg::OP_MAX;
      if (r < 96) return slist_pkg::OP_SIZE;
      if (r < 98) return slist_pkg::OP_CLEAR;
      return OP_UNUSED;
    end
    if (r < 20) return slist_pkg::OP_APPEND;
    if (r < 55) return slist_pkg::OP_REMOVE;
    if (r < 70) return slist_pkg::OP_GET;
    if (r < 78) return slist_pkg::OP_REMOVE_ODD;
    if (r < 88) return slist_pkg::OP_MAX;
    if (r < 94) return slist_pkg::OP_SIZE;
    if (r < 97) return slist_pkg::OP_CLEAR;
    return OP_UNUSED;
  endfunction

  // Offer one command beat after a random idle; note it once accepted
  task automatic send_cmd(input logic [slist_pkg::OP_W-1:0] op, input logic [31:0] val,
                          input logic [5:0] pos);
    int gap;
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= slist_pkg::IN_DATA_W'({pos, val});
    do @(posedge clk); while (!in_tready);
    sb.note_command(op, val, pos);
  endtask

  // Check every result beat taken at a clock edge
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      sb.check_result(out_tuser[0], out_tdata[31:0], out_tdata[37:32]);
  end

  // Result side: random stalls, ready bursts, and one long hold-off
  initial begin
    int stall;
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        stall = pick_idle(recv_calm);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Command stream: directed corners, fill to capacity, then phased random traffic
  initial begin
    bit grow;
    int phase_left;
    logic [slist_pkg::OP_W-1:0] op;
    logic [31:0] val;
    logic [5:0] pos;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    hold_req   = 1'b0;
    send_calm  = 0;
    sb = new();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: size, then the failing commands
    send_cmd(slist_pkg::OP_SIZE,       32'h0, 6'd0);
    send_cmd(slist_pkg::OP_MAX,        32'h0, 6'd0);
    send_cmd(slist_pkg::OP_REMOVE,     32'h0, 6'd0);
    send_cmd(slist_pkg::OP_REMOVE_ODD, 32'h0, 6'd0);
    send_cmd(slist_pkg::OP_GET,        32'h0, 6'd1);
    // Extremes, negative odd/even, duplicate
    send_cmd(slist_pkg::OP_APPEND, Q_MIN,     6'd63);
    send_cmd(slist_pkg::OP_APPEND, Q_MAX,     6'd0);
    send_cmd(slist_pkg::OP_APPEND, Q_NEG_1P5, 6'd0);
    send_cmd(slist_pkg::OP_APPEND, Q_NEG_2P5, 6'd0);
    send_cmd(slist_pkg::OP_APPEND, Q_POS_1P5, 6'd0);
    send_cmd(slist_pkg::OP_APPEND, Q_MAX,     6'd0);
    // Positions: zero, last, one past, top of field
    send_cmd(slist_pkg::OP_GET, 32'h0, 6'd0);
    send_cmd(slist_pkg::OP_GET, 32'h0, 6'd6);
    send_cmd(slist_pkg::OP_GET, 32'h0, 6'd7);
    send_cmd(slist_pkg::OP_GET, 32'h0, 6'd63);
    send_cmd(slist_pkg::OP_MAX, 32'h0, 6'd0);
    // Absent value, then first of two equal entries
    send_cmd(slist_pkg::OP_REMOVE, Q_ABSENT, 6'd0);
    send_cmd(slist_pkg::OP_REMOVE, Q_MAX,    6'd0);
    send_cmd(slist_pkg::OP_GET,    32'h0,    6'd2);
    send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_cmd(slist_pkg::OP_REMOVE_ODD, 32'h0, 6'd0);
    send_cmd(slist_pkg::OP_SIZE,   32'h0, 6'd0);
    send_cmd(slist_pkg::OP_MAX,    32'h0, 6'd0);
    send_cmd(slist_pkg::OP_CLEAR,  32'h0, 6'd0);
    send_cmd(slist_pkg::OP_SIZE,   32'h0, 6'd0);

    // Fill to capacity, then overflow once
    while (sb.entries.size() < slist_pkg::CAPACITY)
      send_cmd(slist_pkg::OP_APPEND, pick_value(), 6'($urandom_range(0, 63)));
    send_cmd(slist_pkg::OP_APPEND, pick_value(), 6'($urandom_range(0, 63)));

    grow = 1'b0;
    phase_left = $urandom_range(20, 60);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_req = 1'b1;
      if (phase_left == 0) begin
        grow = ~grow;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      op  = pick_op(grow);
      val = (op == slist_pkg::OP_REMOVE) ? pick_removal() : pick_value();
      pos = (op == slist_pkg::OP_GET) ? pick_position() : 6'($urandom_range(0, 63));
      send_cmd(op, val, pos);
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sequential_list_engine_tb: PASS");
    end else begin
      $display("sequential_list_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
